[design/assert_macros.svh]
// Assertion macros used by the decoder top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain invariant, checked outside reset.
`define PBD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("invariant violated");

// Same-cycle implication, checked outside reset.
`define PBD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("implication violated");

`endif

[design/pbd_pkg.sv]
// Types, codes and color tables for the bitmap pixel decoder.
package pbd_pkg;

  typedef enum logic [2:0] {
    KIND_SIZE      = 3'd0,
    KIND_PIXEL     = 3'd1,
    KIND_DONE      = 3'd2,
    KIND_SHORT_HDR = 3'd3,
    KIND_BAD_COMP  = 3'd4,
    KIND_BAD_DEPTH = 3'd5,
    KIND_TRUNC     = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_EXT     = 2'd1,
    PH_DATA    = 2'd2,
    PH_DISCARD = 2'd3
  } phase_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PROC,
    S_FIN,
    S_FIN2,
    S_PIX,
    S_DIVGO,
    S_DIVWT,
    S_PIX16,
    S_ROWEND,
    S_EOS,
    S_FLUSH
  } seq_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
  } res_t;

  localparam logic [7:0] COMP_NONE = 8'hFF;
  localparam logic [4:0] CH_BITS_MAX = 5'd16;
  localparam logic [4:0] HDR_LAST = 5'd15;
  localparam logic [4:0] EXT_LAST = 5'd23;
  localparam logic [4:0] EXT_FIRST = 5'd16;

  // Fixed 256-entry system palette, {r, g, b}.
  function automatic logic [23:0] palette_rgb(input logic [7:0] i);
    logic       half;
    logic [7:0] j;
    logic [2:0] a;
    logic [7:0] r18;
    logic [1:0] b1;
    logic [7:0] g6;
    logic [2:0] bi;
    logic [7:0] gv;
    logic [23:0] res;
    half = (i >= 8'd108);
    j = half ? 8'(i - 8'd108) : i;
    a = 3'(j >= 8'd18) + 3'(j >= 8'd36) + 3'(j >= 8'd54) + 3'(j >= 8'd72)
      + 3'(j >= 8'd90);
    r18 = 8'(j - 8'd18 * {5'd0, a});
    b1 = 2'(r18 >= 8'd6) + 2'(r18 >= 8'd12);
    g6 = 8'(r18 - 8'd6 * {6'd0, b1});
    bi = {1'b0, b1} + (half ? 3'd3 : 3'd0);
    gv = 8'd0;
    res = 24'd0;
    if (i < 8'd215) begin
      res = {8'(8'd255 - 8'd51 * {5'd0, a}),
             8'(8'd255 - 8'd51 * g6),
             8'(8'd255 - 8'd51 * {5'd0, bi})};
    end else if (i < 8'd226) begin
      unique case (i)
        8'd215:  gv = 8'd17;
        8'd216:  gv = 8'd34;
        8'd217:  gv = 8'd68;
        8'd218:  gv = 8'd85;
        8'd219:  gv = 8'd119;
        8'd220:  gv = 8'd136;
        8'd221:  gv = 8'd170;
        8'd222:  gv = 8'd187;
        8'd223:  gv = 8'd221;
        8'd224:  gv = 8'd238;
        default: gv = 8'd192;
      endcase
      res = {gv, gv, gv};
    end else begin
      unique case (i)
        8'd226:  res = {8'd128, 8'd0, 8'd0};
        8'd227:  res = {8'd128, 8'd0, 8'd128};
        8'd228:  res = {8'd0, 8'd128, 8'd0};
        8'd229:  res = {8'd0, 8'd128, 8'd128};
        default: res = 24'd0;
      endcase
    end
    return res;
  endfunction

endpackage

[design/pbd_div.sv]
// Restoring divider for channel scaling: quot = num*255/den, one quotient bit a cycle.
module pbd_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] num_i,
  input  logic [15:0] den_i,
  output logic        done_o,
  output logic [7:0]  quot_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [23:0] rem_q, rem_d;
  logic [23:0] dsh_q, dsh_d;
  logic [7:0]  quot_q, quot_d;
  logic        ge;

  assign ge = (rem_q >= dsh_q);

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quot_d = quot_q;
    if (start_i) begin
      rem_d  = 24'({num_i, 8'd0} - {8'd0, num_i});
      dsh_d  = {1'b0, den_i, 7'd0};
      cnt_d  = 3'd0;
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      rem_d  = ge ? 24'(rem_q - dsh_q) : rem_q;
      quot_d = {quot_q[6:0], ge};
      dsh_d  = dsh_q >> 1;
      cnt_d  = 3'(cnt_q + 3'd1);
      if (cnt_q == 3'd7) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

[design/palm_bitmap_pixel_decoder_unit.sv]
// Top level of the uncompressed bitmap pixel decoder.
// One byte is taken per transfer while the decoder is idle; each byte then
// runs through a short sequencer and yields zero to nine results, one per
// cycle while the output does not stall, through a one-deep staging register
// that lets the final result of the byte carry last_of_run. At 16 bpp the odd
// byte of each pixel runs the shared 8-step divider once per channel.
// Output stalls add cycles.
`include "assert_macros.svh"

module palm_bitmap_pixel_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_value_i,
  input  logic        end_of_stream_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [15:0] pixel_x_o,
  output logic [15:0] pixel_y_o,
  output logic [15:0] image_width_o,
  output logic [15:0] image_height_o,
  output logic        last_of_run_o
);

  pbd_pkg::seq_e   seq_q, seq_d;
  pbd_pkg::phase_e phase_q, phase_d;
  logic [4:0]  idx_q, idx_d;
  logic [15:0] width_q, width_d, height_q, height_d, rowb_q, rowb_d, flags_q, flags_d;
  logic [7:0]  depth_q, depth_d, comp_q, comp_d;
  logic [4:0]  chb_q [3];
  logic [4:0]  chb_d [3];
  logic [15:0] row_q, row_d, bir_q, bir_d, col_q, col_d;
  logic [7:0]  held_q, held_d, byte_q, byte_d, sh_q, sh_d;
  logic        eos_q, eos_d;
  logic [3:0]  bitcnt_q, bitcnt_d;
  logic [1:0]  ch_q, ch_d;
  logic [7:0]  chan_q [3];
  logic [7:0]  chan_d [3];
  logic        stg_v_q, stg_v_d, out_v_q, out_v_d, last_q, last_d;
  pbd_pkg::res_t stg_q, stg_d, out_q, out_d;

  logic        accept, adv, gen, flush;
  pbd_pkg::res_t gen_res;
  logic        empty, row_end, last_row, pix_more;
  logic [7:0]  comp_eff;
  logic        depth_ok, fin_err, bad_comp;
  logic [20:0] wd;
  logic [17:0] need;
  logic [15:0] cword, n_sel, mask, div_num;
  logic [4:0]  bits_sel;
  logic        div_start, div_done;
  logic [7:0]  div_quot, grey;
  logic [23:0] pal;

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (seq_q != pbd_pkg::S_IDLE);
  assign adv = !stg_v_q || !out_v_q || !out_stall_i;

  assign empty    = (rowb_q == 16'd0) || (height_q == 16'd0);
  assign row_end  = ({1'b0, bir_q} + 17'd1) >= {1'b0, rowb_q};
  assign last_row = ({1'b0, row_q} + 17'd1) >= {1'b0, height_q};
  assign pix_more = (bitcnt_q != 4'd8) && (col_q < width_q);

  assign comp_eff = flags_q[15] ? comp_q : pbd_pkg::COMP_NONE;
  assign bad_comp = (comp_eff != pbd_pkg::COMP_NONE);
  assign depth_ok = (depth_q == 8'd1) || (depth_q == 8'd2) || (depth_q == 8'd4)
                 || (depth_q == 8'd8) || (depth_q == 8'd16);

  always_comb begin
    unique case (depth_q)
      8'd1:    wd = {5'd0, width_q};
      8'd2:    wd = {4'd0, width_q, 1'b0};
      8'd4:    wd = {3'd0, width_q, 2'b0};
      8'd8:    wd = {2'd0, width_q, 3'b0};
      default: wd = {1'b0, width_q, 4'b0};
    endcase
  end
  assign need = 18'(({1'b0, wd} + 22'd7) >> 3);
  assign fin_err = bad_comp || !depth_ok || (need > {2'd0, rowb_q});

  // Channel operands for the shared divider.
  assign cword = {held_q, byte_q};
  always_comb begin
    unique case (ch_q)
      2'd0: begin
        n_sel    = cword >> (5'd16 - chb_q[0]);
        bits_sel = chb_q[0];
      end
      2'd1: begin
        n_sel    = cword >> chb_q[2];
        bits_sel = chb_q[1];
      end
      default: begin
        n_sel    = cword;
        bits_sel = chb_q[2];
      end
    endcase
  end
  assign mask = 16'((17'd1 << bits_sel) - 17'd1);
  assign div_num = n_sel & mask;
  assign div_start = adv && (seq_q == pbd_pkg::S_DIVGO);

  pbd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (mask),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign pal = pbd_pkg::palette_rgb(sh_q);
  always_comb begin
    unique case (depth_q)
      8'd1:    grey = {8{~sh_q[7]}};
      8'd2:    grey = {4{~sh_q[7:6]}};
      8'd4:    grey = {2{~sh_q[7:4]}};
      default: grey = 8'd0;
    endcase
  end

  // Next state of the sequencer.
  always_comb begin
    seq_d = seq_q;
    if (seq_q == pbd_pkg::S_IDLE) begin
      if (accept) seq_d = pbd_pkg::S_PROC;
    end else if (adv) begin
      unique case (seq_q)
        pbd_pkg::S_PROC: begin
          priority if (phase_q == pbd_pkg::PH_HEADER)
            seq_d = (idx_q == pbd_pkg::HDR_LAST) ? pbd_pkg::S_FIN : pbd_pkg::S_EOS;
          else if (phase_q == pbd_pkg::PH_DATA) begin
            if (depth_q == 8'd16) begin
              if (!bir_q[0]) seq_d = pbd_pkg::S_ROWEND;
              else if (col_q < width_q) seq_d = pbd_pkg::S_DIVGO;
              else seq_d = pbd_pkg::S_ROWEND;
            end else begin
              seq_d = pbd_pkg::S_PIX;
            end
          end else seq_d = pbd_pkg::S_EOS;
        end
        pbd_pkg::S_FIN:
          seq_d = (!fin_err && depth_q != 8'd16 && empty) ? pbd_pkg::S_FIN2 : pbd_pkg::S_EOS;
        pbd_pkg::S_FIN2:  seq_d = pbd_pkg::S_EOS;
        pbd_pkg::S_PIX:   if (!pix_more) seq_d = pbd_pkg::S_ROWEND;
        pbd_pkg::S_DIVGO: seq_d = pbd_pkg::S_DIVWT;
        pbd_pkg::S_DIVWT:
          if (div_done) seq_d = (ch_q == 2'd2) ? pbd_pkg::S_PIX16 : pbd_pkg::S_DIVGO;
        pbd_pkg::S_PIX16:  seq_d = pbd_pkg::S_ROWEND;
        pbd_pkg::S_ROWEND: seq_d = pbd_pkg::S_EOS;
        pbd_pkg::S_EOS:    seq_d = pbd_pkg::S_FLUSH;
        pbd_pkg::S_FLUSH:  seq_d = pbd_pkg::S_IDLE;
        default:           seq_d = pbd_pkg::S_IDLE;
      endcase
    end
  end

  // Datapath and result generation.
  always_comb begin
    phase_d = phase_q;  idx_d = idx_q;
    width_d = width_q;  height_d = height_q;  rowb_d = rowb_q;  flags_d = flags_q;
    depth_d = depth_q;  comp_d = comp_q;
    chb_d = chb_q;  chan_d = chan_q;
    row_d = row_q;  bir_d = bir_q;  col_d = col_q;
    held_d = held_q;  byte_d = byte_q;  eos_d = eos_q;  sh_d = sh_q;
    bitcnt_d = bitcnt_q;  ch_d = ch_q;
    gen = 1'b0;  flush = 1'b0;
    gen_res = '0;
    if (seq_q == pbd_pkg::S_IDLE) begin
      if (accept) begin
        byte_d = byte_value_i;
        eos_d  = end_of_stream_i;
      end
    end else if (adv) begin
      unique case (seq_q)
        pbd_pkg::S_PROC: begin
          unique case (phase_q)
            pbd_pkg::PH_HEADER: begin
              unique case (idx_q)
                5'd0:    width_d  = {byte_q, 8'd0};
                5'd1:    width_d  = {width_q[15:8], byte_q};
                5'd2:    height_d = {byte_q, 8'd0};
                5'd3:    height_d = {height_q[15:8], byte_q};
                5'd4:    rowb_d   = {byte_q, 8'd0};
                5'd5:    rowb_d   = {rowb_q[15:8], byte_q};
                5'd6:    flags_d  = {byte_q, 8'd0};
                5'd7:    flags_d  = {flags_q[15:8], byte_q};
                5'd8:    depth_d  = byte_q;
                5'd13:   comp_d   = byte_q;
                default: ;
              endcase
              idx_d = 5'(idx_q + 5'd1);
            end
            pbd_pkg::PH_EXT: begin
              if (idx_q >= pbd_pkg::EXT_FIRST && idx_q <= 5'd18)
                chb_d[2'(idx_q - pbd_pkg::EXT_FIRST)] =
                  (byte_q > 8'd16) ? pbd_pkg::CH_BITS_MAX : byte_q[4:0];
              idx_d = 5'(idx_q + 5'd1);
              if (idx_q >= pbd_pkg::EXT_LAST) begin
                phase_d = pbd_pkg::PH_DATA;
                if (empty) begin
                  gen = 1'b1;
                  gen_res.kind = pbd_pkg::KIND_DONE;
                  phase_d = pbd_pkg::PH_DISCARD;
                end
              end
            end
            pbd_pkg::PH_DATA: begin
              if (depth_q == 8'd16) begin
                if (!bir_q[0]) held_d = byte_q;
                else if (col_q >= width_q) col_d = 16'(col_q + 16'd1);
                ch_d = 2'd0;
              end else begin
                sh_d = byte_q;
                bitcnt_d = 4'd0;
              end
            end
            default: ;
          endcase
        end
        pbd_pkg::S_FIN: begin
          gen = 1'b1;
          comp_d = comp_eff;
          phase_d = pbd_pkg::PH_DISCARD;
          priority if (bad_comp) gen_res.kind = pbd_pkg::KIND_BAD_COMP;
          else if (fin_err) gen_res.kind = pbd_pkg::KIND_BAD_DEPTH;
          else begin
            gen_res.kind = pbd_pkg::KIND_SIZE;
            gen_res.w = width_q;
            gen_res.h = height_q;
            phase_d = (depth_q == 8'd16) ? pbd_pkg::PH_EXT : pbd_pkg::PH_DATA;
          end
        end
        pbd_pkg::S_FIN2: begin
          gen = 1'b1;
          gen_res.kind = pbd_pkg::KIND_DONE;
          phase_d = pbd_pkg::PH_DISCARD;
        end
        pbd_pkg::S_PIX: begin
          if (pix_more) begin
            gen = 1'b1;
            gen_res.kind = pbd_pkg::KIND_PIXEL;
            gen_res.x = col_q;
            gen_res.y = row_q;
            if (depth_q == 8'd8) begin
              gen_res.red = pal[23:16];  gen_res.green = pal[15:8];  gen_res.blue = pal[7:0];
            end else begin
              gen_res.red = grey;  gen_res.green = grey;  gen_res.blue = grey;
            end
            col_d = 16'(col_q + 16'd1);
            bitcnt_d = 4'(bitcnt_q + depth_q[3:0]);
            sh_d = 8'(sh_q << depth_q[3:0]);
          end
        end
        pbd_pkg::S_DIVWT: begin
          if (div_done) begin
            chan_d[ch_q] = (bits_sel == 5'd0) ? 8'd0 : div_quot;
            ch_d = 2'(ch_q + 2'd1);
          end
        end
        pbd_pkg::S_PIX16: begin
          gen = 1'b1;
          gen_res.kind = pbd_pkg::KIND_PIXEL;
          gen_res.x = col_q;
          gen_res.y = row_q;
          gen_res.red = chan_q[0];  gen_res.green = chan_q[1];  gen_res.blue = chan_q[2];
          col_d = 16'(col_q + 16'd1);
        end
        pbd_pkg::S_ROWEND: begin
          if (row_end) begin
            bir_d = 16'd0;
            col_d = 16'd0;
            row_d = 16'(row_q + 16'd1);
            if (last_row) begin
              gen = 1'b1;
              gen_res.kind = pbd_pkg::KIND_DONE;
              phase_d = pbd_pkg::PH_DISCARD;
            end
          end else begin
            bir_d = 16'(bir_q + 16'd1);
          end
        end
        pbd_pkg::S_EOS: begin
          if (eos_q) begin
            if (phase_q == pbd_pkg::PH_HEADER) begin
              gen = 1'b1;
              gen_res.kind = pbd_pkg::KIND_SHORT_HDR;
            end else if (phase_q != pbd_pkg::PH_DISCARD) begin
              gen = 1'b1;
              gen_res.kind = pbd_pkg::KIND_TRUNC;
            end
            phase_d = pbd_pkg::PH_HEADER;  idx_d = 5'd0;
            width_d = 16'd0;  height_d = 16'd0;  rowb_d = 16'd0;  flags_d = 16'd0;
            depth_d = 8'd0;  comp_d = 8'd0;
            chb_d[0] = 5'd0;  chb_d[1] = 5'd0;  chb_d[2] = 5'd0;
            row_d = 16'd0;  bir_d = 16'd0;  col_d = 16'd0;  held_d = 8'd0;
          end
        end
        pbd_pkg::S_FLUSH: flush = 1'b1;
        default: ;
      endcase
    end
  end

  // Staging and output registers.
  always_comb begin
    stg_v_d = stg_v_q;
    stg_d   = stg_q;
    out_d   = out_q;
    last_d  = last_q;
    out_v_d = out_v_q && out_stall_i;
    if (gen) begin
      if (stg_v_q) begin
        out_d = stg_q;  last_d = 1'b0;  out_v_d = 1'b1;
      end
      stg_d = gen_res;
      stg_v_d = 1'b1;
    end else if (flush && stg_v_q) begin
      out_d = stg_q;  last_d = 1'b1;  out_v_d = 1'b1;
      stg_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= pbd_pkg::S_IDLE;  phase_q <= pbd_pkg::PH_HEADER;  idx_q <= 5'd0;
      width_q <= 16'd0;  height_q <= 16'd0;  rowb_q <= 16'd0;  flags_q <= 16'd0;
      depth_q <= 8'd0;  comp_q <= 8'd0;
      chb_q[0] <= 5'd0;  chb_q[1] <= 5'd0;  chb_q[2] <= 5'd0;
      row_q <= 16'd0;  bir_q <= 16'd0;  col_q <= 16'd0;  held_q <= 8'd0;
      eos_q <= 1'b0;  bitcnt_q <= 4'd0;  ch_q <= 2'd0;
      stg_v_q <= 1'b0;  out_v_q <= 1'b0;
    end else begin
      seq_q <= seq_d;  phase_q <= phase_d;  idx_q <= idx_d;
      width_q <= width_d;  height_q <= height_d;  rowb_q <= rowb_d;  flags_q <= flags_d;
      depth_q <= depth_d;  comp_q <= comp_d;  chb_q <= chb_d;
      row_q <= row_d;  bir_q <= bir_d;  col_q <= col_d;  held_q <= held_d;
      eos_q <= eos_d;  bitcnt_q <= bitcnt_d;  ch_q <= ch_d;
      stg_v_q <= stg_v_d;  out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    sh_q   <= sh_d;
    chan_q <= chan_d;
    stg_q  <= stg_d;
    out_q  <= out_d;
    last_q <= last_d;
  end

  assign out_valid_o    = out_v_q;
  assign kind_o         = out_q.kind;
  assign red_o          = out_q.red;
  assign green_o        = out_q.green;
  assign blue_o         = out_q.blue;
  assign pixel_x_o      = out_q.x;
  assign pixel_y_o      = out_q.y;
  assign image_width_o  = out_q.w;
  assign image_height_o = out_q.h;
  assign last_of_run_o  = last_q;

  `PBD_ASSERT(a_idle_stage_empty, clk_i, rst_ni, !(seq_q == pbd_pkg::S_IDLE && stg_v_q))
  `PBD_ASSERT_IMP(a_ext_only_16bpp, clk_i, rst_ni, phase_q == pbd_pkg::PH_EXT, depth_q == 8'd16)
  `PBD_ASSERT(a_bitcnt_range, clk_i, rst_ni, bitcnt_q <= 4'd8)

endmodule
